// File: hw/rtl/hfw_pkg.sv
// ----------------------------------------------------------------------------
// hfw_pkg
// Shared types and constants for the Haar feature window test.
// ----------------------------------------------------------------------------
package hfw_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_RECT_ONE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TWO      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_THREE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_AREA  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd7;

  localparam int SUM_W     = 22;
  localparam int SQ_W      = 30;
  localparam int ACC_SUM_W = 24;
  localparam int ACC_SQ_W  = 32;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 66;
  localparam int RSUM_W    = 42;
  localparam int RSUMC_W   = 40;
  localparam int LHS_W     = 64;
  localparam int CMP_W     = 70;
  localparam int SQRT_IN_W = 56;
  localparam int ROOT_W    = 28;
  localparam int REM_W     = 31;

  localparam logic signed [PROD_W-1:0] MEAN_LIMIT = 66'sd2147483647;
  localparam logic signed [RSUM_W-1:0] RSUM_LIMIT = 42'sd549755813887;
  localparam logic signed [PROD_W-1:0] ONE_Q24    = 66'sd16777216;
  localparam logic [ROOT_W-1:0]        ONE_Q12    = 28'd4096;

  localparam logic [1:0] SEL_WINDOW = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_WREAD, S_WDRAIN, S_MEAN, S_SQ, S_MM, S_VAR,
    S_RREAD, S_RDRAIN, S_RMUL, S_RACC, S_LO, S_HI, S_HIACC,
    S_SQWAIT, S_THR, S_CMP, S_DONE
  } hfw_state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_MEAN, MUL_SQ, MUL_MM, MUL_RECT, MUL_LO, MUL_HI, MUL_THR
  } hfw_mul_t;

  typedef struct packed {
    logic       load_write;
    logic       start_eval;
    logic       rd_issue;
    logic [1:0] rd_sel;
    logic [1:0] corner;
    logic       acc_clear;
    hfw_mul_t   mul_op;
    logic       mean_capture;
    logic       var_capture;
    logic       sqrt_start;
    logic       rsum_clear;
    logic       rsum_add;
    logic       lhs_lo;
    logic       lhs_hi;
    logic       res_bad;
    logic       res_cmp;
    logic       out_load;
  } hfw_cmd_t;

  typedef struct packed {
    logic       bad;
    logic       sqrt_busy;
    logic [1:0] nrect;
  } hfw_status_t;

endpackage

// File: hw/rtl/hfw_ram.sv
// ----------------------------------------------------------------------------
// hfw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hfw_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 16641
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/hfw_datapath.sv
// ----------------------------------------------------------------------------
// hfw_datapath
// Tables, corner address generation, accumulators, shared multiplier,
// iterative square root, configuration registers and result register.
// ----------------------------------------------------------------------------
module hfw_datapath import hfw_pkg::*; #(
  parameter int IMAGE_WIDTH  = 128,
  parameter int IMAGE_HEIGHT = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            x_pos,
  input  logic [7:0]            y_pos,
  input  logic [SUM_W-1:0]      sum_value,
  input  logic [SQ_W-1:0]       square_value,
  input  hfw_cmd_t              cmd,
  output hfw_status_t           status,
  output logic                  choose_left,
  output logic                  out_of_range
);

  localparam int COLS  = IMAGE_WIDTH + 1;
  localparam int DEPTH = COLS * (IMAGE_HEIGHT + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(IMAGE_WIDTH + IMAGE_HEIGHT + 512);
  localparam logic [CW-1:0] MAX_COL = CW'(IMAGE_WIDTH);
  localparam logic [CW-1:0] MAX_ROW = CW'(IMAGE_HEIGHT);

  // configuration
  logic [47:0]        rect [3];
  logic [1:0]         rect_count;
  logic [7:0]         window_width;
  logic [7:0]         window_height;
  logic [23:0]        inverse_area;
  logic signed [31:0] feature_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect[0]           <= '0;
      rect[1]           <= '0;
      rect[2]           <= '0;
      rect_count        <= 2'd1;
      window_width      <= 8'd24;
      window_height     <= 8'd24;
      inverse_area      <= 24'd29127;
      feature_threshold <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RECT_ONE:      rect[0]           <= cfg_data;
        REG_RECT_TWO:      rect[1]           <= cfg_data;
        REG_RECT_THREE:    rect[2]           <= cfg_data;
        REG_RECT_COUNT:    rect_count        <= cfg_data[1:0];
        REG_WINDOW_WIDTH:  window_width      <= cfg_data[7:0];
        REG_WINDOW_HEIGHT: window_height     <= cfg_data[7:0];
        REG_INVERSE_AREA:  inverse_area      <= cfg_data[23:0];
        REG_THRESHOLD:     feature_threshold <= $signed(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  logic [1:0] nrect;
  assign nrect = (rect_count >= 2'd2) ? rect_count : 2'd1;

  // window origin
  logic [7:0] win_x;
  logic [7:0] win_y;

  always_ff @(posedge clk) begin
    if (cmd.start_eval) begin
      win_x <= x_pos;
      win_y <= y_pos;
    end
  end

  // bounds check
  logic bad;
  always_comb begin
    bad = ((CW'(win_x) + CW'(window_width)) > MAX_COL) ||
          ((CW'(win_y) + CW'(window_height)) > MAX_ROW);
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < nrect) begin
        if (((CW'(win_x) + CW'(rect[i][7:0]))   > MAX_COL) ||
            ((CW'(win_x) + CW'(rect[i][23:16])) > MAX_COL) ||
            ((CW'(win_y) + CW'(rect[i][15:8]))  > MAX_ROW) ||
            ((CW'(win_y) + CW'(rect[i][31:24])) > MAX_ROW)) begin
          bad = 1'b1;
        end
      end
    end
  end

  // corner address
  logic [7:0]    off_l, off_t, off_r, off_b, off_c, off_w;
  logic [CW-1:0] rd_col, rd_row;
  logic [AW-1:0] raddr, waddr;
  logic          wr_en;

  always_comb begin
    if (cmd.rd_sel == SEL_WINDOW) begin
      off_l = 8'd0;
      off_t = 8'd0;
      off_r = window_width;
      off_b = window_height;
    end else begin
      off_l = rect[cmd.rd_sel][7:0];
      off_t = rect[cmd.rd_sel][15:8];
      off_r = rect[cmd.rd_sel][23:16];
      off_b = rect[cmd.rd_sel][31:24];
    end
    off_c  = cmd.corner[0] ? off_l : off_r;
    off_w  = cmd.corner[1] ? off_t : off_b;
    rd_col = CW'(win_x) + CW'(off_c);
    rd_row = CW'(win_y) + CW'(off_w);
    raddr  = AW'(rd_row) * AW'(COLS) + AW'(rd_col);
    waddr  = AW'(y_pos) * AW'(COLS) + AW'(x_pos);
    wr_en  = cmd.load_write && (CW'(x_pos) <= MAX_COL) && (CW'(y_pos) <= MAX_ROW);
  end

  logic [SUM_W-1:0] sum_rdata;
  logic [SQ_W-1:0]  sq_rdata;

  hfw_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (sum_value),
    .raddr (raddr),
    .rdata (sum_rdata)
  );

  hfw_ram #(.WIDTH(SQ_W), .DEPTH(DEPTH)) u_sq_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (square_value),
    .raddr (raddr),
    .rdata (sq_rdata)
  );

  // corner accumulation, sign follows corner order
  logic rd_vld;
  logic rd_neg;
  logic signed [ACC_SUM_W-1:0] acc_sum;
  logic signed [ACC_SQ_W-1:0]  acc_sq;
  logic signed [ACC_SUM_W-1:0] sum_ext;
  logic signed [ACC_SQ_W-1:0]  sq_ext;

  assign sum_ext = $signed(ACC_SUM_W'(sum_rdata));
  assign sq_ext  = $signed(ACC_SQ_W'(sq_rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_neg <= cmd.corner[0] ^ cmd.corner[1];
    if (cmd.acc_clear) begin
      acc_sum <= '0;
      acc_sq  <= '0;
    end else if (rd_vld) begin
      acc_sum <= rd_neg ? acc_sum - sum_ext : acc_sum + sum_ext;
      acc_sq  <= rd_neg ? acc_sq - sq_ext : acc_sq + sq_ext;
    end
  end

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [31:0]        mean;
  logic signed [RSUM_W-1:0]  rsum;
  logic signed [RSUMC_W-1:0] rsum_c;
  logic [ROOT_W-1:0]         sq_root;

  always_comb begin
    case (cmd.mul_op)
      MUL_MEAN: begin
        mul_a = MUL_W'(acc_sum);
        mul_b = $signed(MUL_W'(inverse_area));
      end
      MUL_SQ: begin
        mul_a = MUL_W'(acc_sq);
        mul_b = $signed(MUL_W'(inverse_area));
      end
      MUL_MM: begin
        mul_a = MUL_W'(mean);
        mul_b = MUL_W'(mean);
      end
      MUL_RECT: begin
        mul_a = MUL_W'(acc_sum);
        mul_b = MUL_W'($signed(rect[cmd.rd_sel][47:32]));
      end
      MUL_LO: begin
        mul_a = $signed(MUL_W'(rsum_c[19:0]));
        mul_b = $signed(MUL_W'(inverse_area));
      end
      MUL_HI: begin
        mul_a = MUL_W'($signed(rsum_c[39:20]));
        mul_b = $signed(MUL_W'(inverse_area));
      end
      MUL_THR: begin
        mul_a = MUL_W'(feature_threshold);
        mul_b = $signed(MUL_W'(sq_root));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // mean and variance
  logic signed [PROD_W-1:0] mean_raw;
  logic signed [PROD_W-1:0] var_q;
  logic signed [PROD_W-1:0] var_d;

  assign mean_raw = prod >>> 12;
  assign var_d    = var_q - prod;

  always_ff @(posedge clk) begin
    if (cmd.mean_capture) begin
      if (mean_raw > MEAN_LIMIT) begin
        mean <= 32'sd2147483647;
      end else if (mean_raw < -MEAN_LIMIT) begin
        mean <= -32'sd2147483647;
      end else begin
        mean <= mean_raw[31:0];
      end
    end
    if (cmd.var_capture) begin
      var_q <= prod;
    end
  end

  // restoring square root, two radicand bits per step
  logic                  sqrt_busy;
  logic [4:0]            sq_cnt;
  logic [SQRT_IN_W-1:0]  sq_v;
  logic [REM_W-1:0]      sq_rem;
  logic [REM_W+1:0]      sq_tmp;
  logic [REM_W+1:0]      sq_trial;

  assign sq_tmp   = {sq_rem, sq_v[SQRT_IN_W-1 -: 2]};
  assign sq_trial = (REM_W+2)'({sq_root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_busy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sqrt_busy <= (var_d > ONE_Q24);
    end else if (sqrt_busy && sq_cnt == 5'd0) begin
      sqrt_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_v    <= var_d[SQRT_IN_W-1:0];
      sq_rem  <= '0;
      sq_cnt  <= 5'(ROOT_W - 1);
      sq_root <= (var_d > ONE_Q24) ? '0 : ONE_Q12;
    end else if (sqrt_busy) begin
      sq_v   <= sq_v << 2;
      sq_cnt <= sq_cnt - 5'd1;
      if (sq_tmp >= sq_trial) begin
        sq_rem  <= REM_W'(sq_tmp - sq_trial);
        sq_root <= {sq_root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem  <= REM_W'(sq_tmp);
        sq_root <= {sq_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // rectangle sum and compare
  logic signed [LHS_W-1:0] lhs;
  logic signed [CMP_W-1:0] lhs_x16;
  logic signed [CMP_W-1:0] rhs;
  logic                    cmp;

  always_comb begin
    if (rsum > RSUM_LIMIT) begin
      rsum_c = RSUM_LIMIT[RSUMC_W-1:0];
    end else if (rsum < -RSUM_LIMIT) begin
      rsum_c = RSUMC_W'(-RSUM_LIMIT);
    end else begin
      rsum_c = rsum[RSUMC_W-1:0];
    end
    lhs_x16 = CMP_W'(lhs) <<< 4;
    rhs     = CMP_W'(prod);
    cmp     = lhs_x16 < rhs;
  end

  always_ff @(posedge clk) begin
    if (cmd.rsum_clear) begin
      rsum <= '0;
    end else if (cmd.rsum_add) begin
      rsum <= rsum + prod[RSUM_W-1:0];
    end
    if (cmd.lhs_lo) begin
      lhs <= prod[LHS_W-1:0];
    end else if (cmd.lhs_hi) begin
      lhs <= lhs + (prod[LHS_W-1:0] <<< 20);
    end
  end

  // result
  logic res_left;
  logic res_range;

  always_ff @(posedge clk) begin
    if (cmd.res_bad) begin
      res_left  <= 1'b0;
      res_range <= 1'b1;
    end else if (cmd.res_cmp) begin
      res_left  <= cmp;
      res_range <= 1'b0;
    end
    if (cmd.out_load) begin
      choose_left  <= res_left;
      out_of_range <= res_range;
    end
  end

  assign status.bad       = bad;
  assign status.sqrt_busy = sqrt_busy;
  assign status.nrect     = nrect;

endmodule

// File: hw/rtl/hfw_ctrl.sv
// ----------------------------------------------------------------------------
// hfw_ctrl
// Sequencer for loads and window evaluations, and the output valid flag.
// ----------------------------------------------------------------------------
module hfw_ctrl import hfw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  output logic        out_valid,
  input  logic        out_ready,
  input  hfw_status_t status,
  output hfw_cmd_t    cmd
);

  hfw_state_t state, state_next;
  logic [1:0] cnt, cnt_next;
  logic [1:0] k, k_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_next     = k;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action) begin
            cmd.start_eval = 1'b1;
            state_next     = S_CHECK;
          end else begin
            cmd.load_write = 1'b1;
          end
        end
      end
      S_CHECK: begin
        cmd.acc_clear = 1'b1;
        cnt_next      = '0;
        if (status.bad) begin
          cmd.res_bad = 1'b1;
          state_next  = S_DONE;
        end else begin
          state_next = S_WREAD;
        end
      end
      S_WREAD: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_sel   = SEL_WINDOW;
        cmd.corner   = cnt;
        cnt_next     = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = S_WDRAIN;
        end
      end
      S_WDRAIN: state_next = S_MEAN;
      S_MEAN: begin
        cmd.mul_op = MUL_MEAN;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.mul_op       = MUL_SQ;
        cmd.mean_capture = 1'b1;
        state_next       = S_MM;
      end
      S_MM: begin
        cmd.mul_op      = MUL_MM;
        cmd.var_capture = 1'b1;
        state_next      = S_VAR;
      end
      S_VAR: begin
        cmd.sqrt_start = 1'b1;
        cmd.acc_clear  = 1'b1;
        cmd.rsum_clear = 1'b1;
        k_next         = '0;
        cnt_next       = '0;
        state_next     = S_RREAD;
      end
      S_RREAD: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_sel   = k;
        cmd.corner   = cnt;
        cnt_next     = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = S_RDRAIN;
        end
      end
      S_RDRAIN: state_next = S_RMUL;
      S_RMUL: begin
        cmd.mul_op = MUL_RECT;
        cmd.rd_sel = k;
        state_next = S_RACC;
      end
      S_RACC: begin
        cmd.rsum_add  = 1'b1;
        cmd.acc_clear = 1'b1;
        cnt_next      = '0;
        if (({1'b0, k} + 3'd1) < {1'b0, status.nrect}) begin
          k_next     = k + 2'd1;
          state_next = S_RREAD;
        end else begin
          state_next = S_LO;
        end
      end
      S_LO: begin
        cmd.mul_op = MUL_LO;
        state_next = S_HI;
      end
      S_HI: begin
        cmd.mul_op = MUL_HI;
        cmd.lhs_lo = 1'b1;
        state_next = S_HIACC;
      end
      S_HIACC: begin
        cmd.lhs_hi = 1'b1;
        state_next = S_SQWAIT;
      end
      S_SQWAIT: begin
        if (!status.sqrt_busy) begin
          state_next = S_THR;
        end
      end
      S_THR: begin
        cmd.mul_op = MUL_THR;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.res_cmp = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`ifndef SYNTHESIS
  a_no_read_on_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_issue && cmd.load_write))
    else $error("table read issued during load");

  a_dev_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_op == MUL_THR) |-> !status.sqrt_busy)
    else $error("deviation used while square root busy");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside done state");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !in_ready)
    else $error("input taken while result pending");
`endif

endmodule

// File: hw/rtl/haar_feature_window_test.sv
// ----------------------------------------------------------------------------
// haar_feature_window_test
// Haar feature test on a stored integral and squared integral image.
// ----------------------------------------------------------------------------
// Load item: no result; the next item may follow at once.
// Evaluate item: no new item is taken until its result is loaded, and the
// 28-step square root runs beside the rectangle reads.
// Out-of-range window: no table reads; the result flags out of range.
// A finished result waits, and holds back input, while an earlier one is unread.
// Synchronous reset restores register defaults; table contents are undefined.
module haar_feature_window_test import hfw_pkg::*; #(
  parameter int IMAGE_WIDTH  = 128,
  parameter int IMAGE_HEIGHT = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [7:0]            x_pos,
  input  logic [7:0]            y_pos,
  input  logic [SUM_W-1:0]      sum_value,
  input  logic [SQ_W-1:0]       square_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  choose_left,
  output logic                  out_of_range
);

  hfw_cmd_t    cmd;
  hfw_status_t status;

  hfw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hfw_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .sum_value    (sum_value),
    .square_value (square_value),
    .cmd          (cmd),
    .status       (status),
    .choose_left  (choose_left),
    .out_of_range (out_of_range)
  );

endmodule
